// ===== hw/rtl/sha1h_pkg.sv =====
// shared types and constants for the sha-1 message hasher
// used by sha1h_block_ram, sha1h_rounds, sha1_message_hasher and the checker; no dependencies
package sha1h_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned NumChain  = 5;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned NumRounds = 80;

  localparam logic [WordW-1:0] K0 = 32'h5A827999;
  localparam logic [WordW-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WordW-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WordW-1:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PadMark = 8'h80;

  typedef logic [NumChain-1:0][WordW-1:0] chain_t;

  // word 0 in the lowest bits
  localparam chain_t ChainInit = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                  32'hEFCDAB89, 32'h67452301};

  localparam logic [6:0] LastRound  = 7'd79;
  localparam logic [5:0] LenStart   = 6'd56;
  localparam logic [5:0] LastByte   = 6'd63;
  localparam logic [2:0] LastDigest = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FINAL,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic       init;   // copy chaining words into the working vars
    logic       step;   // run one round
    logic [6:0] round;
  } round_ctrl_t;

endpackage

// ===== hw/rtl/sha1_message_hasher.sv =====
// top level of the sha-1 message hasher: byte intake, padding, block sequencing
// and digest output; depends on sha1h_pkg, sha1h_block_ram and sha1h_rounds
//
//   channel  | dir | tdata               | tuser     | tlast
//   s_axis   | in  | [7:0] data_byte     | has_byte  | end_of_message
//   m_axis   | out | [31:0] digest_word  | -         | last_word
//
// a message byte is taken while the hasher is idle; the 64th byte of a block
// starts a compression (one read of the block store, 80 rounds, one chaining
// add), with the rounds run in turn on the single round unit and one read port.
// end of message writes the padding one byte per cycle, followed by one or two
// compressions, then five digest words go out, one per request.
// s_axis_tready_o is high only while no byte, padding or block is in work;
// a stall on m_axis holds the current digest word. reset restores the
// initial chaining words and clears the counters.
module sha1_message_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] has_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] digest_word
  output logic        m_axis_tlast_o
);
  import sha1h_pkg::*;

  state_e      state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bit_total_q, bit_total_d;
  logic        pad_q, pad_d;
  logic        mark_q, mark_d;
  logic        len_q, len_d;
  logic        done_q, done_d;
  logic [6:0]  round_q, round_d;
  logic [2:0]  word_q, word_d;
  chain_t      chain_q, chain_d;

  logic        in_req, out_req, len_act;
  logic        we, re;
  logic [7:0]  wbyte, len_byte;
  logic [3:0]  raddr;
  logic [WordW-1:0] rdata;
  chain_t      vars;
  round_ctrl_t rctrl;

  sha1h_block_ram u_block_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (fill_q[5:2]),
    .wlane_i (fill_q[1:0]),
    .wbyte_i (wbyte),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  sha1h_rounds u_rounds (
    .clk_i   (clk_i),
    .ctrl_i  (rctrl),
    .chain_i (chain_q),
    .wdata_i (rdata),
    .vars_o  (vars)
  );

  assign in_req  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_req = m_axis_tvalid_o && m_axis_tready_i;

  // length bytes go out big-endian at block positions 56..63
  assign len_act  = len_q || (!mark_q && fill_q == LenStart);
  assign len_byte = bit_total_q[{3'd7 - fill_q[2:0], 3'b000} +: 8];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = (state_q == ST_OUT);
  assign m_axis_tdata_o  = chain_q[word_q];
  assign m_axis_tlast_o  = (word_q == LastDigest);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    bit_total_d = bit_total_q;
    pad_d       = pad_q;
    mark_d      = mark_q;
    len_d       = len_q;
    done_d      = done_q;
    round_d     = round_q;
    word_d      = word_q;
    chain_d     = chain_q;
    we          = 1'b0;
    wbyte       = s_axis_tdata_i;
    re          = 1'b0;
    raddr       = '0;
    rctrl       = '{init: 1'b0, step: 1'b0, round: round_q};

    case (state_q)
      ST_IDLE: begin
        if (in_req) begin
          if (s_axis_tlast_i) begin
            pad_d  = 1'b1;
            mark_d = 1'b1;
            len_d  = 1'b0;
            done_d = 1'b0;
            state_d = ST_PAD;
          end
          if (s_axis_tuser_i) begin
            we          = 1'b1;
            fill_d      = fill_q + 6'd1;
            bit_total_d = bit_total_q + 64'd8;
            if (fill_q == LastByte) begin
              state_d = ST_LOAD;
            end
          end
        end
      end

      ST_PAD: begin
        we     = 1'b1;
        wbyte  = mark_q ? PadMark : (len_act ? len_byte : 8'h00);
        fill_d = fill_q + 6'd1;
        mark_d = 1'b0;
        len_d  = len_act;
        if (fill_q == LastByte) begin
          done_d  = len_act;
          state_d = ST_LOAD;
        end
      end

      ST_LOAD: begin
        re         = 1'b1;
        raddr      = '0;
        rctrl.init = 1'b1;
        round_d    = '0;
        state_d    = ST_ROUND;
      end

      ST_ROUND: begin
        // fetch the next block word while this round consumes the current one
        re         = 1'b1;
        raddr      = round_q[3:0] + 4'd1;
        rctrl.step = 1'b1;
        round_d    = round_q + 7'd1;
        if (round_q == LastRound) begin
          state_d = ST_FINAL;
        end
      end

      ST_FINAL: begin
        for (int i = 0; i < NumChain; i++) begin
          chain_d[i] = chain_q[i] + vars[i];
        end
        if (done_q) begin
          word_d  = '0;
          state_d = ST_OUT;
        end else if (pad_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end

      ST_OUT: begin
        if (out_req) begin
          word_d = word_q + 3'd1;
          if (word_q == LastDigest) begin
            chain_d     = ChainInit;
            bit_total_d = '0;
            fill_d      = '0;
            pad_d       = 1'b0;
            done_d      = 1'b0;
            len_d       = 1'b0;
            state_d     = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      bit_total_q <= '0;
      pad_q       <= 1'b0;
      mark_q      <= 1'b0;
      len_q       <= 1'b0;
      done_q      <= 1'b0;
      round_q     <= '0;
      word_q      <= '0;
      chain_q     <= ChainInit;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      bit_total_q <= bit_total_d;
      pad_q       <= pad_d;
      mark_q      <= mark_d;
      len_q       <= len_d;
      done_q      <= done_d;
      round_q     <= round_d;
      word_q      <= word_d;
      chain_q     <= chain_d;
    end
  end

endmodule

// ===== hw/rtl/sha1h_block_ram.sv =====
// 16 x 32 message block store with byte-lane writes and registered read
// depends on sha1h_pkg
module sha1h_block_ram (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [3:0]                   waddr_i,
  input  logic [1:0]                   wlane_i,
  input  logic [7:0]                   wbyte_i,
  input  logic                         re_i,
  input  logic [3:0]                   raddr_i,
  output logic [sha1h_pkg::WordW-1:0]  rdata_o
);
  import sha1h_pkg::*;

  logic [WordW-1:0] mem [BlockWords];
  logic [WordW-1:0] rdata_q;

  // byte 0 of a word is its most significant byte
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i][{~wlane_i, 3'b000} +: 8] <= wbyte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/sha1h_rounds.sv =====
// sha-1 round datapath: working vars a..e and the rolling message schedule
// depends on sha1h_pkg
module sha1h_rounds (
  input  logic                         clk_i,
  input  sha1h_pkg::round_ctrl_t       ctrl_i,
  input  sha1h_pkg::chain_t            chain_i,
  input  logic [sha1h_pkg::WordW-1:0]  wdata_i,
  output sha1h_pkg::chain_t            vars_o
);
  import sha1h_pkg::*;

  chain_t           vars_q;
  logic [WordW-1:0] sched_q [BlockWords];
  logic [WordW-1:0] a, b, c, d, e;
  logic [WordW-1:0] f, k, w, x, t;

  assign a = vars_q[0];
  assign b = vars_q[1];
  assign c = vars_q[2];
  assign d = vars_q[3];
  assign e = vars_q[4];

  always_comb begin
    // sched_q[0] is the oldest word, sched_q[15] the newest
    x = sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0];
    w = (ctrl_i.round < 7'd16) ? wdata_i : {x[WordW-2:0], x[WordW-1]};
    if (ctrl_i.round < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (ctrl_i.round < 7'd40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (ctrl_i.round < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
    t = {a[WordW-6:0], a[WordW-1:WordW-5]} + f + e + k + w;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.init) begin
      vars_q <= chain_i;
    end else if (ctrl_i.step) begin
      vars_q[4] <= d;
      vars_q[3] <= c;
      vars_q[2] <= {b[1:0], b[WordW-1:2]};
      vars_q[1] <= a;
      vars_q[0] <= t;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step) begin
      for (int i = 0; i < BlockWords - 1; i++) begin
        sched_q[i] <= sched_q[i+1];
      end
      sched_q[BlockWords-1] <= w;
    end
  end

  assign vars_o = vars_q;

endmodule

// ===== verif/sha1_message_hasher_checker.sv =====
// digest checker for sha1_message_hasher: follows both stream channels, keeps its own
// sha-1 state and compares every digest word in order; depends on sha1h_pkg
module sha1_message_hasher_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] has_byte
  input  logic        s_axis_tlast_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [31:0] m_axis_tdata_i,   // [31:0] digest_word
  input  logic        m_axis_tlast_i,
  output int unsigned mismatch_count_o,
  output int unsigned words_pending_o,
  output int unsigned words_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import sha1h_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } digest_word_t;

  chain_t       hash_chain;
  logic [7:0]   block_buf [64];
  int unsigned  block_fill;
  logic [63:0]  msg_bits;
  digest_word_t digest_q [$];
  int unsigned  mismatches;
  int unsigned  words_checked;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void compress_block();
    logic [31:0] sched [16];
    logic [31:0] a, b, c, d, e, f, k, wt, t;
    for (int i = 0; i < 16; i++) begin
      sched[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
    end
    a = hash_chain[0];
    b = hash_chain[1];
    c = hash_chain[2];
    d = hash_chain[3];
    e = hash_chain[4];
    for (int r = 0; r < NumRounds; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      // rolling 16-word schedule
      if (r < 16) begin
        wt = sched[r];
      end else begin
        wt = rotl(sched[(r+13)%16] ^ sched[(r+8)%16] ^ sched[(r+2)%16] ^ sched[r%16], 1);
        sched[r%16] = wt;
      end
      t = rotl(a, 5) + f + e + k + wt;
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    hash_chain[0] += a;
    hash_chain[1] += b;
    hash_chain[2] += c;
    hash_chain[3] += d;
    hash_chain[4] += e;
  endfunction

  function automatic void push_block_byte(input logic [7:0] v);
    block_buf[block_fill] = v;
    block_fill++;
    if (block_fill == 64) begin
      compress_block();
      block_fill = 0;
    end
  endfunction

  function automatic void take_request(input logic has_b, input logic [7:0] d,
                                       input logic eom);
    logic [63:0]  len;
    digest_word_t dw;
    if (has_b) begin
      push_block_byte(d);
      msg_bits += 64'd8;
    end
    if (eom) begin
      len = msg_bits;
      push_block_byte(PadMark);
      while (block_fill != LenStart) push_block_byte(8'h00);
      for (int i = 7; i >= 0; i--) push_block_byte(len[8*i +: 8]);
      for (int i = 0; i < NumChain; i++) begin
        dw.word = hash_chain[i];
        dw.last = (i == LastDigest);
        digest_q.insert(digest_q.size(), dw);
      end
      hash_chain = ChainInit;
      block_fill = 0;
      msg_bits = '0;
    end
  endfunction

  function automatic void check_word(input logic [31:0] word, input logic last);
    digest_word_t want;
    words_checked++;
    if (digest_q.size() == 0) begin
      $display("%0t ns: unexpected digest word %h (last %0b), none pending",
               $time, word, last);
      mismatches++;
    end else begin
      want = digest_q.pop_front();
      if (want.word !== word) begin
        $display("%0t ns: digest word mismatch, expected %h, actual %h",
                 $time, want.word, word);
        mismatches++;
      end
      if (want.last !== last) begin
        $display("%0t ns: last word flag mismatch, expected %0b, actual %0b",
                 $time, want.last, last);
        mismatches++;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_chain = ChainInit;
      block_fill = 0;
      msg_bits = '0;
      digest_q.delete();
    end else begin
      // input first, so a same-cycle digest would still find its expectation
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        take_request(s_axis_tuser_i, s_axis_tdata_i, s_axis_tlast_i);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        check_word(m_axis_tdata_i, m_axis_tlast_i);
      end
    end
    mismatch_count_o <= mismatches;
    words_pending_o  <= digest_q.size();
    words_checked_o  <= words_checked;
  end

endmodule

// ===== verif/sha1_message_hasher_tb.sv =====
// top testbench for sha1_message_hasher: drives byte requests and digest stalls,
// gives the verdict; depends on the hasher rtl and sha1_message_hasher_checker
module sha1_message_hasher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit    = 200_000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned DrainCycles   = 200;
  localparam int unsigned RandItems     = 160;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  int unsigned cycle_count;
  int unsigned msg_count;
  int unsigned byte_count;
  int unsigned longest_msg;
  int unsigned rand_items;
  int unsigned mismatch_count;
  int unsigned words_pending;
  int unsigned words_checked;
  bit          gaps_on;
  bit          stalls_on;
  bit          hold_off_req;
  bit          hold_off_taken;

  always #1 clk_i = ~clk_i;

  sha1_message_hasher dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .s_axis_tlast_i (s_axis_tlast),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tlast_o (m_axis_tlast)
  );

  sha1_message_hasher_checker u_digest_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tlast_i  (m_axis_tlast),
    .mismatch_count_o(mismatch_count),
    .words_pending_o (words_pending),
    .words_checked_o (words_checked)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d digest words pending", cycle_count,
               words_pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // digest side: random stall bursts, one long hold-off on request
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req && !hold_off_taken) begin
        hold_off_taken = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end else if (stalls_on && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  // one request, held until accepted; valid stays high into the next request unless a gap is drawn
  task automatic offer(input bit has_b, input logic [7:0] d, input bit eom);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= has_b;
    s_axis_tdata  <= d;
    s_axis_tlast  <= eom;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_message(input int unsigned n, input bit end_on_byte);
    for (int unsigned i = 0; i < n; i++) begin
      // ignored filler between bytes
      if ($urandom_range(0, 9) == 0) offer(1'b0, 8'($urandom), 1'b0);
      offer(1'b1, 8'($urandom), end_on_byte && (i == n - 1));
    end
    if (!end_on_byte || n == 0) begin
      offer(1'b0, 8'($urandom), 1'b1);
      rand_items++;
    end
    rand_items += n;
    msg_count++;
    byte_count += n;
    if (n > longest_msg) longest_msg = n;
  endtask

  initial begin
    int unsigned n;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer(1'b0, 8'hFF, 1'b0);   // idle, data ignored
    offer(1'b0, 8'h00, 1'b1);   // empty message
    offer(1'b1, 8'h61, 1'b0);
    offer(1'b1, 8'h62, 1'b0);
    offer(1'b1, 8'h63, 1'b1);
    offer(1'b1, 8'h00, 1'b0);
    offer(1'b1, 8'hFF, 1'b0);
    offer(1'b0, 8'hFF, 1'b1);   // end without byte
    offer(1'b1, 8'hFF, 1'b1);
    offer(1'b0, 8'h5A, 1'b0);
    offer(1'b0, 8'h00, 1'b1);   // second empty message right after a digest
    msg_count = 5;
    byte_count = 6;
    longest_msg = 3;
    rand_items = 0;

    while (rand_items < RandItems || msg_count < 9) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      // digest of the 56-byte message sits stalled while the full block waits to come in
      if (msg_count == 7) hold_off_req = 1'b1;
      case (msg_count)
        5: n = 55;   // padding fits in one block
        6: n = 56;   // length spills into a second block
        7: n = 64;   // exactly one full block
        default: begin
          if ($urandom_range(0, 7) == 0) n = $urandom_range(0, 130);
          else n = $urandom_range(0, 20);
        end
      endcase
      send_message(n, $urandom_range(0, 1));
    end

    gaps_on = 1'b0;
    stalls_on = 1'b0;
    repeat (3) send_message($urandom_range(0, 8), $urandom_range(0, 1));
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (words_pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d messages, %0d message bytes, longest %0d bytes, %0d digest words",
             msg_count, byte_count, longest_msg, words_checked);
    $display("with idle bursts on both channels, one long digest hold-off and a quiet tail");
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/sha1h_pkg.sv
hw/rtl/sha1h_block_ram.sv
hw/rtl/sha1h_rounds.sv
hw/rtl/sha1_message_hasher.sv
verif/sha1_message_hasher_checker.sv
verif/sha1_message_hasher_tb.sv
